FILE: src/nkpt_pkg.sv
// Package for the nearest-k position table: sizes, opcodes, status codes, state type.
// No dependencies.
`timescale 1ns / 1ps
package nkpt_pkg;
  localparam int SLOTS = 32;
  localparam int SLOT_W = 5;
  localparam int CNT_W = 6;
  localparam int COORD_W = 16;
  localparam int DIST_W = 34;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_FREE = 2'd2;
  localparam logic [1:0] ST_NONE = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_INS, S_RD, S_SCAN, S_PICK, S_EMIT_RD, S_EMIT
  } state_e;
endpackage

FILE: src/nearest_k_position_table.sv
// Nearest-k position table top level: valid bits in flops, positions in one sync RAM.
// Depends on nkpt_pkg.
// Insert, delete and read strobe their one result in the cycle after acceptance.
// Query: a distance scan over all slots, then per result a min search over a registered
// distance array, a RAM read state (S_EMIT_RD) and the strobe state (S_EMIT); a no-match
// result is strobed at the end of the first min search.
// Throughput: busy stays high through the last result strobe; one transaction at a time.
// Reset clears all valid bits and the sequencer; position RAM is not cleared.
`timescale 1ns / 1ps
module nearest_k_position_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          opcode_i,
  input  logic signed [15:0]  pos_x_i,
  input  logic signed [15:0]  pos_y_i,
  input  logic signed [15:0]  pos_z_i,
  input  logic [4:0]          slot_i,
  input  logic [15:0]         max_distance_i,
  input  logic [5:0]          max_count_i,
  output logic                result_valid_o,
  output logic [1:0]          status_o,
  output logic [4:0]          slot_out_o,
  output logic                entry_valid_o,
  output logic signed [15:0]  out_x_o,
  output logic signed [15:0]  out_y_o,
  output logic signed [15:0]  out_z_o,
  output logic [33:0]         dist_sq_o,
  output logic                last_o
);
  nkpt_pkg::state_e state_q, state_d;

  // position memory, one read port with registered data
  logic [47:0] mem [nkpt_pkg::SLOTS];
  logic [47:0] rdata_q;
  logic        we;
  logic [4:0]  waddr, raddr;
  logic [47:0] wdata;

  logic [31:0] valid_q, valid_d;
  logic [1:0]  op_q;
  logic signed [15:0] px_q, py_q, pz_q;
  logic [4:0]  slot_q, slot_d;
  logic [31:0] r2_q;
  logic [5:0]  idx_q, idx_d;     // scan index (holds 32 at the end)
  logic [5:0]  nout_q, nout_d;   // results still allowed
  logic        any_q, any_d;     // a result was emitted
  // distance per slot, and slots still eligible
  logic [33:0] dist_q [nkpt_pkg::SLOTS];
  logic [31:0] hit_q, hit_d;
  logic [4:0]  best_q, best_d;
  logic [33:0] bestd_q, bestd_d;
  logic        bestv_q, bestv_d;
  logic        dwe;
  logic [33:0] dcalc;
  logic [4:0]  ri;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // squared distance of the entry just read (RAM output) to the query point
  logic signed [16:0] dx, dy, dz;
  logic [33:0] sx, sy, sz;
  always_comb begin
    dx = 17'(signed'(rdata_q[47:32])) - 17'(px_q);
    dy = 17'(signed'(rdata_q[31:16])) - 17'(py_q);
    dz = 17'(signed'(rdata_q[15:0])) - 17'(pz_q);
    sx = 34'(dx * dx);
    sy = 34'(dy * dy);
    sz = 34'(dz * dz);
    dcalc = sx + sy + sz;
  end

  assign ri = 5'(idx_q - 6'd1);

  always_ff @(posedge clk_i) begin
    if (dwe) dist_q[ri] <= dcalc;
  end

  // lowest free slot
  logic       free_any;
  logic [4:0] free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = nkpt_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = 5'(i);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    valid_d = valid_q;
    slot_d = slot_q;
    idx_d = idx_q;
    nout_d = nout_q;
    any_d = any_q;
    hit_d = hit_q;
    best_d = best_q;
    bestd_d = bestd_q;
    bestv_d = bestv_q;
    we = 1'b0;
    waddr = free_idx;
    wdata = {px_q, py_q, pz_q};
    raddr = slot_i;
    dwe = 1'b0;
    busy = (state_q != nkpt_pkg::S_IDLE);
    result_valid_o = 1'b0;
    status_o = nkpt_pkg::ST_OK;
    slot_out_o = '0;
    entry_valid_o = 1'b0;
    out_x_o = '0;
    out_y_o = '0;
    out_z_o = '0;
    dist_sq_o = '0;
    last_o = 1'b1;
    case (state_q)
      nkpt_pkg::S_IDLE: begin
        if (start) begin
          slot_d = slot_i;
          case (opcode_i)
            nkpt_pkg::OP_INSERT: state_d = nkpt_pkg::S_INS;
            nkpt_pkg::OP_QUERY: begin
              nout_d = (max_count_i > 6'd32) ? 6'd32 : max_count_i;
              raddr = '0;
              idx_d = 6'd1;
              hit_d = '0;
              any_d = 1'b0;
              state_d = nkpt_pkg::S_SCAN;
            end
            default: state_d = nkpt_pkg::S_RD;
          endcase
        end
      end
      nkpt_pkg::S_INS: begin
        // insert answers from the registered transaction fields
        result_valid_o = 1'b1;
        if (free_any) begin
          we = 1'b1;
          valid_d[free_idx] = 1'b1;
          slot_out_o = free_idx;
          entry_valid_o = 1'b1;
          out_x_o = px_q;
          out_y_o = py_q;
          out_z_o = pz_q;
        end else begin
          status_o = nkpt_pkg::ST_FULL;
        end
        state_d = nkpt_pkg::S_IDLE;
      end
      nkpt_pkg::S_RD: begin
        result_valid_o = 1'b1;
        slot_out_o = slot_q;
        if (!valid_q[slot_q]) begin
          status_o = nkpt_pkg::ST_FREE;
        end else begin
          out_x_o = rdata_q[47:32];
          out_y_o = rdata_q[31:16];
          out_z_o = rdata_q[15:0];
          entry_valid_o = (op_q == nkpt_pkg::OP_READ);
          if (op_q == nkpt_pkg::OP_DELETE) valid_d[slot_q] = 1'b0;
        end
        state_d = nkpt_pkg::S_IDLE;
      end
      nkpt_pkg::S_SCAN: begin
        // rdata_q holds slot idx_q-1
        dwe = 1'b1;
        hit_d[ri] = valid_q[ri] && (dcalc < {2'b0, r2_q});
        raddr = idx_q[4:0];
        if (idx_q == 6'd32) begin
          idx_d = '0;
          bestv_d = 1'b0;
          state_d = nkpt_pkg::S_PICK;
        end else begin
          idx_d = idx_q + 6'd1;
        end
      end
      nkpt_pkg::S_PICK: begin
        // one slot compared per cycle, strict < keeps the lower slot on ties
        if (idx_q == 6'd32) begin
          if (!bestv_q || nout_q == 6'd0) begin
            if (!any_q) begin
              result_valid_o = 1'b1;
              status_o = nkpt_pkg::ST_NONE;
            end
            state_d = nkpt_pkg::S_IDLE;
          end else begin
            raddr = best_q;
            state_d = nkpt_pkg::S_EMIT_RD;
          end
        end else begin
          if (hit_q[idx_q[4:0]] && (!bestv_q || dist_q[idx_q[4:0]] < bestd_q)) begin
            bestv_d = 1'b1;
            best_d = idx_q[4:0];
            bestd_d = dist_q[idx_q[4:0]];
          end
          idx_d = idx_q + 6'd1;
        end
      end
      nkpt_pkg::S_EMIT_RD: begin
        // hold the read address so rdata_q still carries the picked entry
        raddr = best_q;
        hit_d[best_q] = 1'b0;
        state_d = nkpt_pkg::S_EMIT;
      end
      nkpt_pkg::S_EMIT: begin
        // last when the count runs out or no eligible slot remains
        result_valid_o = 1'b1;
        slot_out_o = best_q;
        entry_valid_o = 1'b1;
        out_x_o = rdata_q[47:32];
        out_y_o = rdata_q[31:16];
        out_z_o = rdata_q[15:0];
        dist_sq_o = bestd_q;
        last_o = (nout_q == 6'd1) || (hit_q == '0);
        any_d = 1'b1;
        nout_d = nout_q - 6'd1;
        idx_d = '0;
        bestv_d = 1'b0;
        state_d = last_o ? nkpt_pkg::S_IDLE : nkpt_pkg::S_PICK;
      end
      default: state_d = nkpt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nkpt_pkg::S_IDLE;
      valid_q <= '0;
      idx_q <= '0;
      nout_q <= '0;
      any_q <= 1'b0;
      hit_q <= '0;
      bestv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      idx_q <= idx_d;
      nout_q <= nout_d;
      any_q <= any_d;
      hit_q <= hit_d;
      bestv_q <= bestv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    bestd_q <= bestd_d;
    slot_q <= slot_d;
    if (start && !busy) begin
      op_q <= opcode_i;
      px_q <= pos_x_i;
      py_q <= pos_y_i;
      pz_q <= pos_z_i;
      r2_q <= 32'(max_distance_i) * 32'(max_distance_i);
    end
  end
endmodule
